// File: design/tna_pkg.sv
// Package: widths and constants of the triangle normal and area block.
package tna_pkg;
  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned NormFracDef   = 14;
endpackage

// File: design/triangle_normal_and_area.sv
// Top level: triangle unit normal and area pipeline.
// Usage:
//   Drive the nine vertex coordinates and raise start; busy is always
//   low, so a triangle is taken at every clock edge with start high.
//   Each triangle yields one word on normal_*_o, area_o and degenerate_o,
//   marked by done_o for one cycle; the receiver cannot hold it off.
// Pipeline:
//   A triangle passes through the six front stages (edges, products,
//   cross product, magnitudes, squares, sum), the one-bit-per-stage square
//   root, the one-bit-per-stage normal dividers and the output register.
// Throughput:
//   One triangle per cycle, sustained.
// Reset:
//   Clears all valid bits; words in flight are dropped, no results appear
//   until new triangles are taken.
module triangle_normal_and_area #(
  parameter int unsigned COORD_WIDTH = tna_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC_BITS = tna_pkg::NormFracDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      ax_i,
  input  logic signed [COORD_WIDTH-1:0]      ay_i,
  input  logic signed [COORD_WIDTH-1:0]      az_i,
  input  logic signed [COORD_WIDTH-1:0]      bx_i,
  input  logic signed [COORD_WIDTH-1:0]      by_i,
  input  logic signed [COORD_WIDTH-1:0]      bz_i,
  input  logic signed [COORD_WIDTH-1:0]      cx_i,
  input  logic signed [COORD_WIDTH-1:0]      cy_i,
  input  logic signed [COORD_WIDTH-1:0]      cz_i,
  output logic                               done_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic [2*COORD_WIDTH:0]             area_o,
  output logic                               degenerate_o
);
  import tna_pkg::*;
  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned XW = PW + 1;
  localparam int unsigned MW = PW;
  localparam int unsigned SW = 2 * MW + 2;
  localparam int unsigned RW0 = SW / 2;
  localparam int unsigned SqW = 2 * RW0;
  localparam int unsigned TagW = 3 * (MW + 1);
  localparam int unsigned NW = NORMAL_FRAC_BITS + 2;
  localparam int unsigned DL = NORMAL_FRAC_BITS + 1;

  assign busy = 1'b0;

  // stage 1: edges
  logic                 v1_q;
  logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    e1x_q <= EW'(bx_i) - EW'(ax_i);
    e1y_q <= EW'(by_i) - EW'(ay_i);
    e1z_q <= EW'(bz_i) - EW'(az_i);
    e2x_q <= EW'(cx_i) - EW'(ax_i);
    e2y_q <= EW'(cy_i) - EW'(ay_i);
    e2z_q <= EW'(cz_i) - EW'(az_i);
  end

  // stage 2: products
  logic                 v2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    p0_q <= e1y_q * e2z_q;
    p1_q <= e1z_q * e2y_q;
    p2_q <= e1z_q * e2x_q;
    p3_q <= e1x_q * e2z_q;
    p4_q <= e1x_q * e2y_q;
    p5_q <= e1y_q * e2x_q;
  end

  // stage 3: cross product
  logic                 v3_q;
  logic signed [XW-1:0] xx_q, xy_q, xz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    xx_q <= XW'(p0_q) - XW'(p1_q);
    xy_q <= XW'(p2_q) - XW'(p3_q);
    xz_q <= XW'(p4_q) - XW'(p5_q);
  end

  // stage 4: magnitudes and signs
  logic          v4_q;
  logic [MW-1:0] mx_q, my_q, mz_q;
  logic          sx_q, sy_q, sz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    mx_q <= MW'(xx_q[XW-1] ? -xx_q : xx_q);
    my_q <= MW'(xy_q[XW-1] ? -xy_q : xy_q);
    mz_q <= MW'(xz_q[XW-1] ? -xz_q : xz_q);
    sx_q <= xx_q[XW-1];
    sy_q <= xy_q[XW-1];
    sz_q <= xz_q[XW-1];
  end

  // stage 5: squares
  logic            v5_q;
  logic [2*MW-1:0] qx_q, qy_q, qz_q;
  logic [TagW-1:0] t5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    qx_q <= mx_q * mx_q;
    qy_q <= my_q * my_q;
    qz_q <= mz_q * mz_q;
    t5_q <= {sx_q, mx_q, sy_q, my_q, sz_q, mz_q};
  end

  // stage 6: sum of squares
  logic            v6_q;
  logic [SqW-1:0]  sum_q;
  logic [TagW-1:0] t6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    sum_q <= SqW'(qx_q) + SqW'(qy_q) + SqW'(qz_q);
    t6_q  <= t5_q;
  end

  logic            vs;
  logic [RW0-1:0]  len;
  logic [TagW-1:0] ts;
  tna_sqrt #(.InW(SqW), .TagW(TagW)) u_sqrt (
    .clk_i (clk_i), .rst_ni(rst_ni), .vld_i(v6_q), .rad_i(sum_q),
    .tag_i (t6_q), .vld_o(vs), .root_o(len), .tag_o(ts)
  );

  logic [MW-1:0]   tmx, tmy, tmz;
  logic            tsx, tsy, tsz;
  assign {tsx, tmx, tsy, tmy, tsz, tmz} = ts;

  logic [DL-1:0] qxo, qyo, qzo;
  tna_div #(.DenW(RW0), .FracW(NORMAL_FRAC_BITS)) u_divx (
    .clk_i(clk_i), .num_i(RW0'(tmx)), .den_i(len), .quo_o(qxo));
  tna_div #(.DenW(RW0), .FracW(NORMAL_FRAC_BITS)) u_divy (
    .clk_i(clk_i), .num_i(RW0'(tmy)), .den_i(len), .quo_o(qyo));
  tna_div #(.DenW(RW0), .FracW(NORMAL_FRAC_BITS)) u_divz (
    .clk_i(clk_i), .num_i(RW0'(tmz)), .den_i(len), .quo_o(qzo));

  // delay line beside the dividers
  logic [DL:0]    dv_q;
  logic [2:0]     ds_q [DL+1];
  logic [RW0-1:0] dl_q [DL+1];
  always_comb begin
    dv_q[0] = vs;
    ds_q[0] = {tsx, tsy, tsz};
    dl_q[0] = len;
  end
  for (genvar s = 0; s < DL; s++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[s+1] <= 1'b0;
      else dv_q[s+1] <= dv_q[s];
    end
    always_ff @(posedge clk_i) begin
      ds_q[s+1] <= ds_q[s];
      dl_q[s+1] <= dl_q[s];
    end
  end

  // output register
  logic          done_q;
  logic [NW-1:0] nx_q, ny_q, nz_q;
  logic [2*COORD_WIDTH:0] area_q;
  logic          deg_q;
  logic          zero_len;
  assign zero_len = dl_q[DL] == '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= dv_q[DL];
  end
  always_ff @(posedge clk_i) begin
    nx_q   <= zero_len ? '0 : (ds_q[DL][2] ? -NW'(qxo) : NW'(qxo));
    ny_q   <= zero_len ? '0 : (ds_q[DL][1] ? -NW'(qyo) : NW'(qyo));
    nz_q   <= zero_len ? '0 : (ds_q[DL][0] ? -NW'(qzo) : NW'(qzo));
    area_q <= (2*COORD_WIDTH+1)'(dl_q[DL] >> 1);
    deg_q  <= zero_len;
  end

  assign done_o       = done_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign area_o       = area_q;
  assign degenerate_o = deg_q;
endmodule

// File: design/tna_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
module tna_sqrt #(
  parameter int unsigned InW = 72,
  parameter int unsigned TagW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [InW-1:0]           rad_i,
  input  logic [TagW-1:0]          tag_i,
  output logic                     vld_o,
  output logic [InW/2-1:0]         root_o,
  output logic [TagW-1:0]          tag_o
);
  import tna_pkg::*;
  localparam int unsigned RW = InW / 2;
  localparam int unsigned RemW = RW + 2;

  logic [RW:0]          vld_q;
  logic [InW-1:0]       rad_q  [RW+1];
  logic [RemW-1:0]      rem_q  [RW+1];
  logic [RW-1:0]        root_q [RW+1];
  logic [TagW-1:0]      tag_q  [RW+1];

  always_comb begin
    vld_q[0]  = vld_i;
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RemW-1:0] rem_d;
    logic [RemW-1:0] trial;
    logic            ge;
    always_comb begin
      rem_d = {rem_q[s][RemW-3:0], rad_q[s][InW-1 -: 2]};
      trial = {root_q[s], 2'b01};
      ge    = rem_d >= trial;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1]  <= {rad_q[s][InW-3:0], 2'b00};
      rem_q[s+1]  <= ge ? rem_d - trial : rem_d;
      root_q[s+1] <= {root_q[s][RW-2:0], ge};
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign tag_o  = tag_q[RW];
endmodule

// File: design/tna_div.sv
// Pipelined restoring fraction divider: trunc(num * 2^FracW / den), num <= den.
module tna_div #(
  parameter int unsigned DenW = 36,
  parameter int unsigned FracW = 14
) (
  input  logic                 clk_i,
  input  logic [DenW-1:0]      num_i,
  input  logic [DenW-1:0]      den_i,
  output logic [FracW:0]       quo_o
);
  import tna_pkg::*;
  localparam int unsigned NS = FracW + 1;

  logic [DenW:0]   rem_q [NS+1];
  logic [DenW-1:0] den_q [NS+1];
  logic [FracW:0]  quo_q [NS+1];

  always_comb begin
    rem_q[0] = {1'b0, num_i};
    den_q[0] = den_i;
    quo_q[0] = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DenW+1:0] sh;
    logic            ge;
    always_comb begin
      sh = (s == 0) ? {1'b0, rem_q[s]} : {rem_q[s], 1'b0};
      ge = sh >= {2'b00, den_q[s]};
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? (DenW+1)'(sh - {2'b00, den_q[s]}) : sh[DenW:0];
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= {quo_q[s][FracW-1:0], ge};
    end
  end

  assign quo_o = quo_q[NS];
endmodule

// File: dv/triangle_normal_and_area_test.sv
// Testbench: checks triangle unit normal and area against an exact integer predictor.
`timescale 1ns / 1ps

module triangle_normal_and_area_test;
  import tna_pkg::*;

  localparam int unsigned CW = CoordWidthDef;
  localparam int unsigned NF = NormFracDef;
  localparam int unsigned NW = NF + 2;
  localparam int unsigned AW = 2 * CW + 1;
  localparam int unsigned LATENCY = 57;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic signed [NW-1:0] nx, ny, nz;
    logic [AW-1:0]        area;
    logic                 degen;
  } geom_t;

  logic clk_i, rst_ni, start, busy, done_o, degenerate_o;
  coord_t ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i;
  logic signed [NW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [AW-1:0] area_o;

  tri_t  pending_tris[$];
  geom_t expected_geom[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    gap = 0;
  bit    stim_done = 0;

  triangle_normal_and_area dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .ax_i(ax_i), .ay_i(ay_i), .az_i(az_i), .bx_i(bx_i), .by_i(by_i), .bz_i(bz_i),
    .cx_i(cx_i), .cy_i(cy_i), .cz_i(cz_i), .done_o(done_o),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o), .normal_z_o(normal_z_o),
    .area_o(area_o), .degenerate_o(degenerate_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [127:0] isqrt128(logic [127:0] s);
    logic [127:0] root, cand;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= s) root = cand;
    end
    return root;
  endfunction

  function automatic logic signed [NW-1:0] unit_comp(longint c, logic [127:0] len);
    logic [127:0] mag, q;
    mag = (c < 0) ? -c : c;
    q = (mag << NF) / len;
    return (c < 0) ? -q[NW-1:0] : q[NW-1:0];
  endfunction

  function automatic geom_t triangle_geometry(tri_t t);
    longint e1x, e1y, e1z, e2x, e2y, e2z, xx, xy, xz;
    logic [127:0] sum, len;
    geom_t g;
    e1x = longint'(t.bx) - t.ax; e1y = longint'(t.by) - t.ay; e1z = longint'(t.bz) - t.az;
    e2x = longint'(t.cx) - t.ax; e2y = longint'(t.cy) - t.ay; e2z = longint'(t.cz) - t.az;
    xx = e1y * e2z - e1z * e2y;
    xy = e1z * e2x - e1x * e2z;
    xz = e1x * e2y - e1y * e2x;
    sum = 128'(xx) * 128'(xx) + 128'(xy) * 128'(xy) + 128'(xz) * 128'(xz);
    len = isqrt128(sum);
    g = '0;
    if (len == 0) begin
      g.degen = 1'b1;
    end else begin
      g.nx = unit_comp(xx, len);
      g.ny = unit_comp(xy, len);
      g.nz = unit_comp(xz, len);
      g.area = len[AW:1];
    end
    return g;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1: return coord_t'($signed($urandom_range(0, 8)) - 4);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: begin
        t.bx = t.ax; t.by = t.ay; t.bz = t.az;
      end
      1: begin
        // collinear unless it wraps: C mirrors B around A, modulo the coordinate width
        t.cx = 2 * t.ax - t.bx; t.cy = 2 * t.ay - t.by; t.cz = 2 * t.az - t.bz;
      end
      default: ;
    endcase
    return t;
  endfunction

  initial begin
    tri_t t;
    coord_t mx, mn;
    mx = coord_t'(16'h7fff);
    mn = coord_t'(16'h8000);
    pending_tris.push_back('0);
    pending_tris.push_back({mn, mn, mn, mx, mn, mn, mn, mx, mn});
    pending_tris.push_back({mx, mx, mx, mn, mx, mx, mx, mn, mx});
    pending_tris.push_back({mn, mn, mn, mx, mx, mx, mn, mn, mx});
    pending_tris.push_back({mx, mn, mx, mn, mx, mn, mx, mx, mn});
    pending_tris.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                            16'sd0, 16'sd256, 16'sd0});
    pending_tris.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1,
                            16'sd1, 16'sd0, 16'sd0});
    pending_tris.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1,
                            16'sd2, 16'sd2, 16'sd2});
    pending_tris.push_back({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5,
                            16'sd9, 16'sd1, 16'sd3});
    pending_tris.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, -16'sd1});
    pending_tris.push_back({-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0,
                            16'sd1, 16'sd2, 16'sd3});
    for (int i = 0; i < 1000; i++) pending_tris.push_back(rand_tri());
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} <= '0;
      gap <= 0;
    end else begin
      if (start && !busy) expected_geom.push_back(triangle_geometry(
          {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i}));
      if (!start || !busy) begin
        if (gap > 0) begin
          start <= 1'b0;
          gap <= gap - 1;
        end else if (pending_tris.size() > 0) begin
          {ax_i, ay_i, az_i, bx_i, by_i, bz_i, cx_i, cy_i, cz_i} <=
              pending_tris.pop_front();
          start <= 1'b1;
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    geom_t want;
    if (rst_ni) begin
      idle_cycles <= (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (done_o) begin
        if (expected_geom.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: area %0d", area_o);
        end else begin
          want = expected_geom.pop_front();
          if (normal_x_o !== want.nx || normal_y_o !== want.ny || normal_z_o !== want.nz
              || area_o !== want.area || degenerate_o !== want.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected n=(%0d,%0d,%0d) area=%0d deg=%0b, ",
                        "got n=(%0d,%0d,%0d) area=%0d deg=%0b"},
                       want.nx, want.ny, want.nz, want.area, want.degen,
                       normal_x_o, normal_y_o, normal_z_o, area_o, degenerate_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && expected_geom.size() == 0) && idle_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (mismatches == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
    end
    $finish;
  end
endmodule
